[sv/mau_pkg.sv]
`timescale 1ns / 1ps
// Shared types, command codes and helpers for the modular arithmetic unit.
// No dependencies.
package mau_pkg;

    localparam int MOD_W = 32;
    localparam int OPND_W = 64;
    localparam int COEF_W = 34;   // Bezout coefficients, |c| <= modulus
    localparam int MUL_W = 34;
    localparam int CNT_W = 7;
    localparam int CMD_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd998244353;
    localparam logic [CNT_W-1:0] DIV_FULL = 7'd64;
    localparam logic [CNT_W-1:0] DIV_HALF = 7'd32;

    // Operation selector codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_INV = 3'd5;
    localparam logic [2:0] OP_POW = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;   // gives result 0

    // Register index
    localparam logic REG_MODULUS = 1'b0;

    // Datapath commands
    localparam logic [CMD_W-1:0] CMD_NOP        = 5'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD       = 5'd1;
    localparam logic [CMD_W-1:0] CMD_DIV_A      = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SET_A      = 5'd3;
    localparam logic [CMD_W-1:0] CMD_DIV_B      = 5'd4;
    localparam logic [CMD_W-1:0] CMD_SET_B      = 5'd5;
    localparam logic [CMD_W-1:0] CMD_FIN_SIMPLE = 5'd6;
    localparam logic [CMD_W-1:0] CMD_MUL_AB     = 5'd7;
    localparam logic [CMD_W-1:0] CMD_MUL_AI     = 5'd8;
    localparam logic [CMD_W-1:0] CMD_MUL_ACC    = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MUL_SQ     = 5'd10;
    localparam logic [CMD_W-1:0] CMD_MUL_TC     = 5'd11;
    localparam logic [CMD_W-1:0] CMD_DIV_PROD   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_SET_RES    = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SET_ACC    = 5'd14;
    localparam logic [CMD_W-1:0] CMD_SET_BASE   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_INIT_INV_A = 5'd16;
    localparam logic [CMD_W-1:0] CMD_INIT_INV_B = 5'd17;
    localparam logic [CMD_W-1:0] CMD_INIT_INV_C = 5'd18;
    localparam logic [CMD_W-1:0] CMD_DIV_PQ     = 5'd19;
    localparam logic [CMD_W-1:0] CMD_EU_UPD     = 5'd20;
    localparam logic [CMD_W-1:0] CMD_DIV_C1     = 5'd21;
    localparam logic [CMD_W-1:0] CMD_SET_INV    = 5'd22;
    localparam logic [CMD_W-1:0] CMD_POW_INIT   = 5'd23;
    localparam logic [CMD_W-1:0] CMD_RES_ACC    = 5'd24;
    localparam logic [CMD_W-1:0] CMD_PUSH       = 5'd25;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [OPND_W-1:0] operand_a;
        logic signed [OPND_W-1:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic [MOD_W-1:0] result;
        logic             equal;
    } out_beat_t;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic       q_zero;
        logic       e_zero;
        logic       e_lsb;
        logic       neg;
        logic [2:0] op;
    } dp_stat_t;

    function automatic logic [OPND_W-1:0] abs64(input logic [OPND_W-1:0] x);
        abs64 = x[OPND_W-1] ? (~x + 64'd1) : x;
    endfunction

    // Residue of a signed value given the remainder of its magnitude
    function automatic logic [MOD_W-1:0] fix_sign(input logic [MOD_W-1:0] rem,
                                                  input logic neg,
                                                  input logic [MOD_W-1:0] m);
        fix_sign = (neg && (rem != '0)) ? (m - rem) : rem;
    endfunction

endpackage

[sv/mau_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 64- or 32-bit dividend,
// 32-bit divisor. Depends on mau_pkg.
module mau_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         half,
    input  logic [mau_pkg::OPND_W-1:0]   dividend,
    input  logic [mau_pkg::MOD_W-1:0]    divisor,
    output logic                         busy,
    output logic [mau_pkg::OPND_W-1:0]   quo,
    output logic [mau_pkg::MOD_W-1:0]    rem
);

    logic [mau_pkg::OPND_W-1:0] dvd_reg, dvd_next;
    logic [mau_pkg::OPND_W-1:0] quo_reg, quo_next;
    logic [mau_pkg::MOD_W-1:0]  rem_reg, rem_next;
    logic [mau_pkg::MOD_W-1:0]  dsr_reg, dsr_next;
    logic [mau_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [mau_pkg::MOD_W:0]    trial;
    logic                       fits;

    assign trial = {rem_reg, dvd_reg[mau_pkg::OPND_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dvd_next  = half ? {dividend[mau_pkg::MOD_W-1:0], {mau_pkg::MOD_W{1'b0}}}
                             : dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = half ? mau_pkg::DIV_HALF : mau_pkg::DIV_FULL;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[mau_pkg::OPND_W-2:0], 1'b0};
            quo_next  = {quo_reg[mau_pkg::OPND_W-2:0], fits};
            rem_next  = fits ? 32'(trial - {1'b0, dsr_reg}) : trial[mau_pkg::MOD_W-1:0];
            cnt_next  = cnt_reg - 7'd1;
            busy_next = (cnt_reg != 7'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[sv/mau_dp.sv]
`timescale 1ns / 1ps
// Datapath: operand and work registers, shared multiplier, divider instance.
// Depends on mau_pkg and mau_div.
module mau_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mau_pkg::dp_cmd_t            cmd,
    input  mau_pkg::in_beat_t           in_beat,
    input  logic [mau_pkg::MOD_W-1:0]   m_eff,
    output mau_pkg::dp_stat_t           stat,
    output mau_pkg::out_beat_t          out_beat
);

    localparam int P_W = 2 * mau_pkg::MUL_W;

    mau_pkg::in_beat_t          raw_reg;
    logic [mau_pkg::MOD_W-1:0]  a_reg, b_reg, acc_reg, base_reg, inv_reg, res_reg;
    logic [mau_pkg::MOD_W-1:0]  p_reg, q_reg;
    logic signed [mau_pkg::COEF_W-1:0] c1_reg, c2_reg;
    logic [mau_pkg::OPND_W-1:0] e_reg, prod_reg;
    logic                       neg_reg, eq_reg;
    mau_pkg::out_beat_t         out_reg;

    logic signed [mau_pkg::MUL_W-1:0] mx, my;
    logic signed [P_W-1:0]            mp;
    logic                             div_start, div_half, div_busy;
    logic [mau_pkg::OPND_W-1:0]       div_dvd, div_quo;
    logic [mau_pkg::MOD_W-1:0]        div_dsr, div_rem;
    logic [mau_pkg::OPND_W-1:0]       c1_ext;
    logic [mau_pkg::MOD_W:0]          sum, diff;
    logic [mau_pkg::MOD_W-1:0]        simple_res;

    assign c1_ext = {{(mau_pkg::OPND_W-mau_pkg::COEF_W){c1_reg[mau_pkg::COEF_W-1]}}, c1_reg};

    // multiplier operand select
    always_comb begin
        case (cmd.code)
            mau_pkg::CMD_MUL_AB: begin
                mx = {2'b00, a_reg};
                my = {2'b00, b_reg};
            end
            mau_pkg::CMD_MUL_AI: begin
                mx = {2'b00, a_reg};
                my = {2'b00, inv_reg};
            end
            mau_pkg::CMD_MUL_ACC: begin
                mx = {2'b00, acc_reg};
                my = {2'b00, base_reg};
            end
            mau_pkg::CMD_MUL_SQ: begin
                mx = {2'b00, base_reg};
                my = {2'b00, base_reg};
            end
            mau_pkg::CMD_MUL_TC: begin
                mx = {1'b0, div_quo[mau_pkg::MUL_W-2:0]};
                my = c2_reg;
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
    end
    assign mp = mx * my;

    // divider operand select
    always_comb begin
        div_start = 1'b1;
        div_half  = 1'b0;
        div_dsr   = m_eff;
        case (cmd.code)
            mau_pkg::CMD_DIV_A:    div_dvd = mau_pkg::abs64(raw_reg.operand_a);
            mau_pkg::CMD_DIV_B:    div_dvd = mau_pkg::abs64(raw_reg.operand_b);
            mau_pkg::CMD_DIV_PROD: div_dvd = prod_reg;
            mau_pkg::CMD_DIV_C1:   div_dvd = mau_pkg::abs64(c1_ext);
            mau_pkg::CMD_DIV_PQ: begin
                div_dvd  = {{(mau_pkg::OPND_W-mau_pkg::MOD_W){1'b0}}, p_reg};
                div_half = 1'b1;
                div_dsr  = q_reg;
            end
            default: begin
                div_dvd   = '0;
                div_start = 1'b0;
            end
        endcase
    end

    mau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .half     (div_half),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // combinational add, subtract and negate on reduced operands
    always_comb begin
        sum  = {1'b0, a_reg} + {1'b0, b_reg};
        diff = {1'b0, a_reg} + {1'b0, m_eff} - {1'b0, b_reg};
        case (raw_reg.op)
            mau_pkg::OP_ADD: simple_res = (sum >= {1'b0, m_eff}) ? 32'(sum - {1'b0, m_eff})
                                                                : sum[mau_pkg::MOD_W-1:0];
            mau_pkg::OP_SUB: simple_res = (a_reg >= b_reg) ? (a_reg - b_reg)
                                                           : diff[mau_pkg::MOD_W-1:0];
            mau_pkg::OP_NEG: simple_res = (a_reg == '0) ? '0 : (m_eff - a_reg);
            default:         simple_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (cmd.code)
            mau_pkg::CMD_LOAD:   raw_reg <= in_beat;
            mau_pkg::CMD_SET_A:  a_reg <= mau_pkg::fix_sign(div_rem,
                                          raw_reg.operand_a[mau_pkg::OPND_W-1], m_eff);
            mau_pkg::CMD_SET_B: begin
                b_reg  <= mau_pkg::fix_sign(div_rem,
                                            raw_reg.operand_b[mau_pkg::OPND_W-1], m_eff);
                eq_reg <= a_reg == mau_pkg::fix_sign(div_rem,
                                            raw_reg.operand_b[mau_pkg::OPND_W-1], m_eff);
            end
            mau_pkg::CMD_FIN_SIMPLE: res_reg <= simple_res;
            mau_pkg::CMD_MUL_AB, mau_pkg::CMD_MUL_AI, mau_pkg::CMD_MUL_ACC,
            mau_pkg::CMD_MUL_SQ, mau_pkg::CMD_MUL_TC: prod_reg <= mp[mau_pkg::OPND_W-1:0];
            mau_pkg::CMD_SET_RES: res_reg <= div_rem;
            mau_pkg::CMD_SET_ACC: acc_reg <= div_rem;
            mau_pkg::CMD_SET_BASE: begin
                base_reg <= div_rem;
                e_reg    <= e_reg >> 1;
            end
            mau_pkg::CMD_INIT_INV_A, mau_pkg::CMD_INIT_INV_B, mau_pkg::CMD_INIT_INV_C: begin
                if (cmd.code == mau_pkg::CMD_INIT_INV_A) begin
                    p_reg <= a_reg;
                end else if (cmd.code == mau_pkg::CMD_INIT_INV_B) begin
                    p_reg <= b_reg;
                end else begin
                    p_reg <= acc_reg;
                end
                q_reg  <= m_eff;
                c1_reg <= 34'sd1;
                c2_reg <= '0;
            end
            mau_pkg::CMD_EU_UPD: begin
                p_reg  <= q_reg;
                q_reg  <= div_rem;
                c1_reg <= c2_reg;
                c2_reg <= c1_reg - $signed(prod_reg[mau_pkg::COEF_W-1:0]);
            end
            mau_pkg::CMD_SET_INV: begin
                inv_reg <= mau_pkg::fix_sign(div_rem, c1_reg[mau_pkg::COEF_W-1], m_eff);
                res_reg <= mau_pkg::fix_sign(div_rem, c1_reg[mau_pkg::COEF_W-1], m_eff);
            end
            mau_pkg::CMD_POW_INIT: begin
                acc_reg  <= (m_eff == 32'd1) ? '0 : 32'd1;
                base_reg <= a_reg;
                e_reg    <= mau_pkg::abs64(raw_reg.operand_b);
                neg_reg  <= raw_reg.operand_b[mau_pkg::OPND_W-1];
            end
            mau_pkg::CMD_RES_ACC: res_reg <= acc_reg;
            mau_pkg::CMD_PUSH: begin
                out_reg.result <= res_reg;
                out_reg.equal  <= eq_reg;
            end
            default: ;
        endcase
    end

    assign stat.div_busy = div_busy;
    assign stat.q_zero   = (q_reg == '0);
    assign stat.e_zero   = (e_reg == '0);
    assign stat.e_lsb    = e_reg[0];
    assign stat.neg      = neg_reg;
    assign stat.op       = raw_reg.op;
    assign out_beat      = out_reg;

endmodule

[sv/mau_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences reduction, modular multiply, Euclid and power steps.
// Depends on mau_pkg.
module mau_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mau_pkg::dp_stat_t  stat,
    output mau_pkg::dp_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RA      = 4'd1;
    localparam logic [3:0] S_RA_W    = 4'd2;
    localparam logic [3:0] S_RB      = 4'd3;
    localparam logic [3:0] S_RB_W    = 4'd4;
    localparam logic [3:0] S_DISP    = 4'd5;
    localparam logic [3:0] S_EU      = 4'd6;
    localparam logic [3:0] S_EU_W    = 4'd7;
    localparam logic [3:0] S_EU_UPD  = 4'd8;
    localparam logic [3:0] S_EU_C1W  = 4'd9;
    localparam logic [3:0] S_DIVMUL  = 4'd10;
    localparam logic [3:0] S_MM_DIV  = 4'd11;
    localparam logic [3:0] S_MM_WAIT = 4'd12;
    localparam logic [3:0] S_POW     = 4'd13;
    localparam logic [3:0] S_POW_SQ  = 4'd14;
    localparam logic [3:0] S_DONE    = 4'd15;

    // where a modular product lands
    localparam logic [1:0] D_RES  = 2'd0;
    localparam logic [1:0] D_ACC  = 2'd1;
    localparam logic [1:0] D_BASE = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] dest_reg, dest_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        dest_next  = dest_reg;
        cmd.code   = mau_pkg::CMD_NOP;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.code   = mau_pkg::CMD_LOAD;
                    state_next = S_RA;
                end
            end
            S_RA: begin
                cmd.code   = mau_pkg::CMD_DIV_A;
                state_next = S_RA_W;
            end
            S_RA_W: begin
                if (!stat.div_busy) begin
                    cmd.code   = mau_pkg::CMD_SET_A;
                    state_next = S_RB;
                end
            end
            S_RB: begin
                cmd.code   = mau_pkg::CMD_DIV_B;
                state_next = S_RB_W;
            end
            S_RB_W: begin
                if (!stat.div_busy) begin
                    cmd.code   = mau_pkg::CMD_SET_B;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.op)
                    mau_pkg::OP_MUL: begin
                        cmd.code   = mau_pkg::CMD_MUL_AB;
                        dest_next  = D_RES;
                        state_next = S_MM_DIV;
                    end
                    mau_pkg::OP_DIV: begin
                        cmd.code   = mau_pkg::CMD_INIT_INV_B;
                        state_next = S_EU;
                    end
                    mau_pkg::OP_INV: begin
                        cmd.code   = mau_pkg::CMD_INIT_INV_A;
                        state_next = S_EU;
                    end
                    mau_pkg::OP_POW: begin
                        cmd.code   = mau_pkg::CMD_POW_INIT;
                        state_next = S_POW;
                    end
                    default: begin
                        cmd.code   = mau_pkg::CMD_FIN_SIMPLE;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_EU: begin
                if (stat.q_zero) begin
                    cmd.code   = mau_pkg::CMD_DIV_C1;
                    state_next = S_EU_C1W;
                end else begin
                    cmd.code   = mau_pkg::CMD_DIV_PQ;
                    state_next = S_EU_W;
                end
            end
            S_EU_W: begin
                if (!stat.div_busy) begin
                    cmd.code   = mau_pkg::CMD_MUL_TC;
                    state_next = S_EU_UPD;
                end
            end
            S_EU_UPD: begin
                cmd.code   = mau_pkg::CMD_EU_UPD;
                state_next = S_EU;
            end
            S_EU_C1W: begin
                if (!stat.div_busy) begin
                    cmd.code   = mau_pkg::CMD_SET_INV;
                    state_next = (stat.op == mau_pkg::OP_DIV) ? S_DIVMUL : S_DONE;
                end
            end
            S_DIVMUL: begin
                cmd.code   = mau_pkg::CMD_MUL_AI;
                dest_next  = D_RES;
                state_next = S_MM_DIV;
            end
            S_MM_DIV: begin
                cmd.code   = mau_pkg::CMD_DIV_PROD;
                state_next = S_MM_WAIT;
            end
            S_MM_WAIT: begin
                if (!stat.div_busy) begin
                    case (dest_reg)
                        D_ACC: begin
                            cmd.code   = mau_pkg::CMD_SET_ACC;
                            state_next = S_POW_SQ;
                        end
                        D_BASE: begin
                            cmd.code   = mau_pkg::CMD_SET_BASE;
                            state_next = S_POW;
                        end
                        default: begin
                            cmd.code   = mau_pkg::CMD_SET_RES;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_POW: begin
                if (stat.e_zero) begin
                    if (stat.neg) begin
                        cmd.code   = mau_pkg::CMD_INIT_INV_C;
                        state_next = S_EU;
                    end else begin
                        cmd.code   = mau_pkg::CMD_RES_ACC;
                        state_next = S_DONE;
                    end
                end else if (stat.e_lsb) begin
                    cmd.code   = mau_pkg::CMD_MUL_ACC;
                    dest_next  = D_ACC;
                    state_next = S_MM_DIV;
                end else begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                cmd.code   = mau_pkg::CMD_MUL_SQ;
                dest_next  = D_BASE;
                state_next = S_MM_DIV;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.code   = mau_pkg::CMD_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.code == mau_pkg::CMD_PUSH) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            dest_reg    <= D_RES;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dest_reg    <= dest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[sv/modular_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Top level: modulus register on the APB port, controller and datapath.
// Depends on mau_pkg, mau_ctrl, mau_dp.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------
//  input    | s_valid / s_ready  | s_data  (op, operand_a, operand_b)
//  result   | m_valid / m_ready  | m_data  (result, equal)
//  config   | psel/penable/pwrite| paddr, pwdata, prdata (modulus @0)
//
// One item at a time; the bit-serial divider sets the run time. Operand
// reduction is two full passes, a modular multiply one more, a Euclid step
// a half-width pass. Add/sub/negate need only reduction; power squares per
// exponent bit, multiplies per set bit, inverts for a negative exponent.
// Reset is synchronous; the modulus returns to 998244353. A waiting result
// in the output register does not block acceptance of the next item.
module modular_arithmetic_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mau_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mau_pkg::out_beat_t              m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mau_pkg::PADDR_W-1:0]     paddr,
    input  logic [mau_pkg::PDATA_W-1:0]     pwdata,
    output logic [mau_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic [mau_pkg::MOD_W-1:0] modulus_reg;
    logic [mau_pkg::MOD_W-1:0] m_eff;
    mau_pkg::dp_cmd_t          cmd;
    mau_pkg::dp_stat_t         stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mau_pkg::REG_MODULUS) ? modulus_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= mau_pkg::MODULUS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == mau_pkg::REG_MODULUS)) begin
            modulus_reg <= pwdata;
        end
    end

    // zero modulus behaves as one
    assign m_eff = (modulus_reg == '0) ? 32'd1 : modulus_reg;

    mau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mau_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_beat  (s_data),
        .m_eff    (m_eff),
        .stat     (stat),
        .out_beat (m_data)
    );

`ifndef ASSERT_OFF
    // one item in flight: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

    // a fresh result is always a proper residue
    a_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.result < m_eff))
        else $error("result not reduced");

    // with a trivial modulus every operand reduces to zero
    a_trivial_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) && (m_eff == 32'd1)) |-> m_data.equal)
        else $error("equal flag wrong for modulus one");
`endif

endmodule
